[rtl/core/rlrsl_pkg.sv]
// types and constants for the run-length ring sample log
`default_nettype none

package rlrsl_pkg;

    localparam logic [1:0] OP_LOG   = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // 16364.0 and -16364.0 in q15.16
    localparam logic signed [31:0] MARK_LOW_RESET  = 32'sh3FEC_0000;
    localparam logic signed [31:0] MARK_HIGH_RESET = 32'shC014_0000;

    localparam int DIV_STEPS = 32;
    localparam int DIV_CNT_W = 5;

    typedef struct packed {
        logic        [1:0]  operation;
        logic        [31:0] time_stamp;
        logic signed [31:0] sample_value;
        logic        [7:0]  read_index;
    } req_beat_t;

    typedef struct packed {
        logic               accepted;
        logic        [31:0] sample_count;
        logic signed [31:0] min_value;
        logic signed [31:0] max_value;
        logic signed [31:0] mean_value;
        logic        [8:0]  stored_runs;
        logic               read_valid;
        logic        [31:0] run_last_number;
        logic signed [31:0] run_value;
    } rsp_beat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_MUL,
        ST_LOAD,
        ST_DIV,
        ST_SIGN,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

[rtl/core/run_length_ring_sample_log.sv]
// top level: run-length ring sample log with running min, max and mean
// a taken sample goes through decode, multiply, load, 32 restoring divide steps for the mean,
// sign and done before it reaches the result register; the next beat is taken back in idle
// read, clear, unused and rejected beats go from decode straight to done
// a stalled result holds the next item in its last state; the ring ram read is registered
// reset (rst_n low, async) clears statistics, counters and ring pointers, not ring contents
`default_nettype none

module run_length_ring_sample_log #(
    parameter int RING_DEPTH = 256
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 req_valid,
    output logic                      req_ready,
    input  wire rlrsl_pkg::req_beat_t req,
    output logic                      rsp_valid,
    input  wire logic                 rsp_ready,
    output rlrsl_pkg::rsp_beat_t      rsp
);

    localparam int SW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int RW = $clog2(RING_DEPTH + 1);
    localparam int CW = ((RW > 8) ? RW : 8) + 2;

    rlrsl_pkg::state_t state_reg, state_next;

    rlrsl_pkg::req_beat_t req_reg, req_next;
    rlrsl_pkg::rsp_beat_t rsp_reg, rsp_next;
    logic rsp_valid_reg, rsp_valid_next;

    logic [SW-1:0]      write_slot_reg, write_slot_next;
    logic [RW-1:0]      runs_held_reg, runs_held_next;
    logic [31:0]        last_time_reg, last_time_next;
    logic [31:0]        count_reg, count_next;
    logic signed [31:0] low_reg, low_next;
    logic signed [31:0] high_reg, high_next;
    logic signed [31:0] mean_reg, mean_next;

    logic               acc_reg, acc_next;
    logic               rvalid_reg, rvalid_next;
    logic [63:0]        prod_reg, prod_next;
    logic               neg_reg, neg_next;
    logic [31:0]        rem_reg, rem_next;
    logic [31:0]        dvd_reg, dvd_next;
    logic [rlrsl_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;

    // ring ram
    logic [63:0]   ring_mem [RING_DEPTH];
    logic [63:0]   rd_data_reg;
    logic          rd_en;
    logic [SW-1:0] rd_addr;
    logic          wr_en;
    logic [SW-1:0] wr_addr;
    logic [63:0]   wr_data;

    logic [SW-1:0]      newest;
    logic [CW-1:0]      slot_sum;
    logic [SW-1:0]      read_slot;
    logic               idx_ok;
    logic signed [65:0] prod_full;
    logic [63:0]        num;
    logic [63:0]        mag;
    logic [33:0]        trial;
    logic               run_match;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ring_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= ring_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= rlrsl_pkg::ST_IDLE;
            rsp_valid_reg  <= 1'b0;
            write_slot_reg <= '0;
            runs_held_reg  <= '0;
            last_time_reg  <= '0;
            count_reg      <= '0;
            low_reg        <= rlrsl_pkg::MARK_LOW_RESET;
            high_reg       <= rlrsl_pkg::MARK_HIGH_RESET;
            mean_reg       <= '0;
            cnt_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            rsp_valid_reg  <= rsp_valid_next;
            write_slot_reg <= write_slot_next;
            runs_held_reg  <= runs_held_next;
            last_time_reg  <= last_time_next;
            count_reg      <= count_next;
            low_reg        <= low_next;
            high_reg       <= high_next;
            mean_reg       <= mean_next;
            cnt_reg        <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        rsp_reg    <= rsp_next;
        acc_reg    <= acc_next;
        rvalid_reg <= rvalid_next;
        prod_reg   <= prod_next;
        neg_reg    <= neg_next;
        rem_reg    <= rem_next;
        dvd_reg    <= dvd_next;
    end

    // address arithmetic
    always_comb
    begin
        newest = (write_slot_reg == '0) ? SW'(RING_DEPTH - 1) : write_slot_reg - SW'(1);
        idx_ok = CW'(req_reg.read_index) < CW'(runs_held_reg);
        slot_sum = CW'(write_slot_reg) + CW'(req_reg.read_index) - CW'(runs_held_reg);
        if (slot_sum[CW-1])
        begin
            slot_sum = slot_sum + CW'(RING_DEPTH);
        end
        read_slot = slot_sum[SW-1:0];
    end

    // shared datapath terms
    always_comb
    begin
        prod_full = $signed(mean_reg) * $signed({1'b0, count_reg - 32'd1});
        num = prod_reg + {{32{req_reg.sample_value[31]}}, req_reg.sample_value};
        mag = num[63] ? (64'd0 - num) : num;
        trial = {1'b0, rem_reg, dvd_reg[31]} - {2'b00, count_reg};
        run_match = (runs_held_reg != '0)
            && (rd_data_reg[63:32] == req_reg.sample_value);
    end

    always_comb
    begin
        state_next      = state_reg;
        req_next        = req_reg;
        rsp_next        = rsp_reg;
        rsp_valid_next  = rsp_valid_reg;
        write_slot_next = write_slot_reg;
        runs_held_next  = runs_held_reg;
        last_time_next  = last_time_reg;
        count_next      = count_reg;
        low_next        = low_reg;
        high_next       = high_reg;
        mean_next       = mean_reg;
        acc_next        = acc_reg;
        rvalid_next     = rvalid_reg;
        prod_next       = prod_reg;
        neg_next        = neg_reg;
        rem_next        = rem_reg;
        dvd_next        = dvd_reg;
        cnt_next        = cnt_reg;
        rd_en           = 1'b0;
        rd_addr         = newest;
        wr_en           = 1'b0;
        wr_addr         = write_slot_reg;
        wr_data         = {req_reg.sample_value, count_reg};
        req_ready       = 1'b0;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            rlrsl_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    req_next   = req;
                    state_next = rlrsl_pkg::ST_DECODE;
                end
            end

            rlrsl_pkg::ST_DECODE:
            begin
                acc_next    = 1'b0;
                rvalid_next = 1'b0;
                state_next  = rlrsl_pkg::ST_DONE;
                case (req_reg.operation)
                    rlrsl_pkg::OP_LOG:
                    begin
                        if (req_reg.time_stamp > last_time_reg)
                        begin
                            acc_next       = 1'b1;
                            last_time_next = req_reg.time_stamp;
                            if (count_reg != '1)
                            begin
                                count_next = count_reg + 32'd1;
                            end
                            if (high_reg < req_reg.sample_value)
                            begin
                                high_next = req_reg.sample_value;
                            end
                            if (low_reg > req_reg.sample_value)
                            begin
                                low_next = req_reg.sample_value;
                            end
                            rd_en      = 1'b1;
                            rd_addr    = newest;
                            state_next = rlrsl_pkg::ST_MUL;
                        end
                    end
                    rlrsl_pkg::OP_READ:
                    begin
                        if (idx_ok)
                        begin
                            rvalid_next = 1'b1;
                            rd_en       = 1'b1;
                            rd_addr     = read_slot;
                        end
                    end
                    rlrsl_pkg::OP_CLEAR:
                    begin
                        write_slot_next = '0;
                        runs_held_next  = '0;
                        last_time_next  = '0;
                        count_next      = '0;
                        low_next        = rlrsl_pkg::MARK_LOW_RESET;
                        high_next       = rlrsl_pkg::MARK_HIGH_RESET;
                        mean_next       = '0;
                    end
                    default:
                    begin
                    end
                endcase
            end

            rlrsl_pkg::ST_MUL:
            begin
                prod_next = prod_full[63:0];
                // extend the newest run or open a new one
                wr_en = 1'b1;
                if (run_match)
                begin
                    wr_addr = newest;
                end
                else
                begin
                    wr_addr = write_slot_reg;
                    write_slot_next = (write_slot_reg == SW'(RING_DEPTH - 1))
                        ? '0 : write_slot_reg + SW'(1);
                    if (runs_held_reg != RW'(RING_DEPTH))
                    begin
                        runs_held_next = runs_held_reg + RW'(1);
                    end
                end
                state_next = rlrsl_pkg::ST_LOAD;
            end

            rlrsl_pkg::ST_LOAD:
            begin
                // quotient stays below 2^32, so the high word is already below n
                neg_next   = num[63];
                rem_next   = mag[63:32];
                dvd_next   = mag[31:0];
                cnt_next   = '0;
                state_next = rlrsl_pkg::ST_DIV;
            end

            rlrsl_pkg::ST_DIV:
            begin
                if (!trial[33])
                begin
                    rem_next = trial[31:0];
                    dvd_next = {dvd_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_next = {rem_reg[30:0], dvd_reg[31]};
                    dvd_next = {dvd_reg[30:0], 1'b0};
                end
                cnt_next = cnt_reg + rlrsl_pkg::DIV_CNT_W'(1);
                if (cnt_reg == rlrsl_pkg::DIV_CNT_W'(rlrsl_pkg::DIV_STEPS - 1))
                begin
                    state_next = rlrsl_pkg::ST_SIGN;
                end
            end

            rlrsl_pkg::ST_SIGN:
            begin
                mean_next  = neg_reg ? (32'sd0 - $signed(dvd_reg)) : $signed(dvd_reg);
                state_next = rlrsl_pkg::ST_DONE;
            end

            rlrsl_pkg::ST_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next.accepted        = acc_reg;
                    rsp_next.sample_count    = count_reg;
                    rsp_next.min_value       = low_reg;
                    rsp_next.max_value       = high_reg;
                    rsp_next.mean_value      = mean_reg;
                    rsp_next.stored_runs     = 9'(runs_held_reg);
                    rsp_next.read_valid      = rvalid_reg;
                    rsp_next.run_last_number = rvalid_reg ? rd_data_reg[31:0] : '0;
                    rsp_next.run_value       = rvalid_reg ? rd_data_reg[63:32] : '0;
                    rsp_valid_next           = 1'b1;
                    state_next               = rlrsl_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = rlrsl_pkg::ST_IDLE;
            end
        endcase
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

[rtl/core/rlrsl_checker.sv]
// port-level checks for the run-length ring sample log, bound to the top level
`default_nettype none

module rlrsl_checker (
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 req_valid,
    input wire logic                 req_ready,
    input wire rlrsl_pkg::req_beat_t req,
    input wire logic                 rsp_valid,
    input wire logic                 rsp_ready,
    input wire rlrsl_pkg::rsp_beat_t rsp
);

    // a stalled result beat holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("result beat changed while stalled");

    // one item at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while an item is in work");

    // a beat is never both a taken sample and a read
    a_acc_excl_read: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.accepted |-> !rsp.read_valid)
        else $error("accepted and read_valid both set");

    // read fields are zero without a valid read
    a_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.read_valid |-> rsp.run_last_number == '0 && rsp.run_value == '0)
        else $error("read fields nonzero without a valid read");

    // an empty log holds no runs and reset marks
    a_empty_log: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.sample_count == '0 |-> rsp.stored_runs == '0
            && rsp.min_value == rlrsl_pkg::MARK_LOW_RESET
            && rsp.max_value == rlrsl_pkg::MARK_HIGH_RESET
            && rsp.mean_value == '0)
        else $error("empty log reports stale statistics");

endmodule

bind run_length_ring_sample_log rlrsl_checker u_rlrsl_checker (.*);

`default_nettype wire

[bench/tb_top.sv]
`timescale 1ns / 1ps
// testbench for the run-length ring sample log: directed and random beats checked by a predictor
module tb_top;

    localparam int RING_DEPTH = 256;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SETTLE_CYCLES = 60;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_BEATS = 400;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    rlrsl_pkg::req_beat_t req = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rlrsl_pkg::rsp_beat_t rsp;

    int send_idle_pct = 0;
    int rsp_stall_pct = 0;
    logic hold_armed = 1'b0;
    int hold_left = 0;
    int mismatch_count = 0;
    int cycle_count = 0;

    // predicted state of the log
    logic signed [31:0] log_ring_value [RING_DEPTH];
    logic [31:0] log_ring_number [RING_DEPTH];
    logic [7:0] log_write_slot;
    logic [8:0] log_runs_held;
    logic [31:0] log_last_time;
    logic [31:0] log_count;
    logic signed [31:0] log_low;
    logic signed [31:0] log_high;
    logic signed [31:0] log_mean;
    logic signed [31:0] last_sent_value = '0;

    rlrsl_pkg::rsp_beat_t expected_results [$];

    run_length_ring_sample_log #(
        .RING_DEPTH(RING_DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp(rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_top failed");
            $finish;
        end
    end

    function automatic void clear_log_state();
        log_write_slot = '0;
        log_runs_held = '0;
        log_last_time = '0;
        log_count = '0;
        log_low = rlrsl_pkg::MARK_LOW_RESET;
        log_high = rlrsl_pkg::MARK_HIGH_RESET;
        log_mean = '0;
    endfunction

    function automatic rlrsl_pkg::rsp_beat_t predict_log_result(rlrsl_pkg::req_beat_t b);
        rlrsl_pkg::rsp_beat_t r;
        logic [7:0] newest;
        logic [7:0] slot;
        longint m64;
        longint n64;
        longint v64;
        r = '0;
        case (b.operation)
            rlrsl_pkg::OP_LOG:
            begin
                if (b.time_stamp > log_last_time)
                begin
                    r.accepted = 1'b1;
                    log_last_time = b.time_stamp;
                    if (log_count != 32'hFFFF_FFFF)
                        log_count = log_count + 32'd1;
                    if ($signed(log_high) < $signed(b.sample_value))
                        log_high = b.sample_value;
                    if ($signed(log_low) > $signed(b.sample_value))
                        log_low = b.sample_value;
                    m64 = $signed(log_mean);
                    n64 = {32'd0, log_count};
                    v64 = $signed(b.sample_value);
                    log_mean = 32'((m64 * (n64 - 64'sd1) + v64) / n64);
                    newest = log_write_slot - 8'd1;
                    if (log_runs_held != 0 && log_ring_value[newest] == b.sample_value)
                        log_ring_number[newest] = log_count;
                    else
                    begin
                        log_ring_value[log_write_slot] = b.sample_value;
                        log_ring_number[log_write_slot] = log_count;
                        log_write_slot = log_write_slot + 8'd1;
                        if (log_runs_held < RING_DEPTH)
                            log_runs_held = log_runs_held + 9'd1;
                    end
                end
            end
            rlrsl_pkg::OP_READ:
            begin
                if ({1'b0, b.read_index} < log_runs_held)
                begin
                    slot = log_write_slot - log_runs_held[7:0] + b.read_index;
                    r.read_valid = 1'b1;
                    r.run_last_number = log_ring_number[slot];
                    r.run_value = log_ring_value[slot];
                end
            end
            rlrsl_pkg::OP_CLEAR:
                clear_log_state();
            default:
                ;
        endcase
        r.sample_count = log_count;
        r.min_value = log_low;
        r.max_value = log_high;
        r.mean_value = log_mean;
        r.stored_runs = log_runs_held;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: mismatch in %s: got %h, expected %h", $time, what, got, want);
        mismatch_count++;
    endtask

    // receiver: random stalls, or a long hold-off once armed
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            rsp_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_armed)
        begin
            rsp_ready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_armed <= 1'b0;
        end
        else
            rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
    end

    always @(posedge clk)
    begin
        rlrsl_pkg::rsp_beat_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (expected_results.size() == 0)
                report_mismatch("unexpected result beat", rsp.sample_count, '0);
            else
            begin
                want = expected_results.pop_front();
                if (rsp.accepted !== want.accepted)
                    report_mismatch("accepted", 32'(rsp.accepted), 32'(want.accepted));
                if (rsp.sample_count !== want.sample_count)
                    report_mismatch("sample_count", rsp.sample_count, want.sample_count);
                if (rsp.min_value !== want.min_value)
                    report_mismatch("min_value", rsp.min_value, want.min_value);
                if (rsp.max_value !== want.max_value)
                    report_mismatch("max_value", rsp.max_value, want.max_value);
                if (rsp.mean_value !== want.mean_value)
                    report_mismatch("mean_value", rsp.mean_value, want.mean_value);
                if (rsp.stored_runs !== want.stored_runs)
                    report_mismatch("stored_runs", 32'(rsp.stored_runs),
                                    32'(want.stored_runs));
                if (rsp.read_valid !== want.read_valid)
                    report_mismatch("read_valid", 32'(rsp.read_valid), 32'(want.read_valid));
                if (rsp.run_last_number !== want.run_last_number)
                    report_mismatch("run_last_number", rsp.run_last_number,
                                    want.run_last_number);
                if (rsp.run_value !== want.run_value)
                    report_mismatch("run_value", rsp.run_value, want.run_value);
            end
        end
    end

    function automatic rlrsl_pkg::req_beat_t make_beat(logic [1:0] op, logic [31:0] stamp,
                                                       logic signed [31:0] value,
                                                       logic [7:0] index);
        rlrsl_pkg::req_beat_t b;
        b.operation = op;
        b.time_stamp = stamp;
        b.sample_value = value;
        b.read_index = index;
        return b;
    endfunction

    function automatic rlrsl_pkg::req_beat_t random_beat();
        rlrsl_pkg::req_beat_t b;
        int unsigned pick;
        logic [32:0] later;
        b.time_stamp = $urandom;
        b.sample_value = $urandom;
        b.read_index = 8'($urandom);
        pick = $urandom_range(99);
        if (pick < 70)
            b.operation = rlrsl_pkg::OP_LOG;
        else if (pick < 95)
            b.operation = rlrsl_pkg::OP_READ;
        else if (pick < 98)
            b.operation = OP_UNUSED;
        else
            b.operation = rlrsl_pkg::OP_CLEAR;
        if (b.operation == rlrsl_pkg::OP_READ && log_runs_held != 0 && $urandom_range(4) != 0)
            b.read_index = 8'($urandom_range(log_runs_held - 9'd1));
        if (b.operation == rlrsl_pkg::OP_LOG)
        begin
            pick = $urandom_range(99);
            later = {1'b0, log_last_time} + $urandom_range(1, 1000);
            if (pick < 80)
                b.time_stamp = later[32] ? 32'hFFFF_FFFF : later[31:0];
            else if (pick < 88)
                b.time_stamp = log_last_time;
            else if (pick < 90)
                b.time_stamp = '0;
            pick = $urandom_range(99);
            if (pick < 35)
                b.sample_value = last_sent_value;
            else if (pick < 70)
                b.sample_value = $urandom_range(0, 32'h7FD8_0000) - 32'h3FEC_0000;
            else if (pick < 85)
            begin
                case ($urandom_range(3))
                    0: b.sample_value = 32'sh0001_8000;
                    1: b.sample_value = -32'sh0001_8000;
                    2: b.sample_value = 32'sh0000_0001;
                    default: b.sample_value = '0;
                endcase
            end
        end
        return b;
    endfunction

    task automatic send_beat(input rlrsl_pkg::req_beat_t b);
        if ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        req <= b;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        expected_results.push_back(predict_log_result(b));
        if (b.operation == rlrsl_pkg::OP_LOG)
            last_sent_value = b.sample_value;
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input int beats);
        send_idle_pct = idle_pct;
        rsp_stall_pct = stall_pct;
        repeat (beats) send_beat(random_beat());
        drain();
    endtask

    task automatic test_directed();
        send_beat(make_beat(rlrsl_pkg::OP_READ, '0, '0, 8'd0));
        send_beat(make_beat(OP_UNUSED, 32'hFFFF_FFFF, 32'sh7FFF_FFFF, 8'hFF));
        // time zero never accepted
        send_beat(make_beat(rlrsl_pkg::OP_LOG, 32'd0, 32'sh0001_0000, 8'd0));
        // beyond the marks: the first becomes the max, the second the min
        send_beat(make_beat(rlrsl_pkg::OP_LOG, 32'd10, 32'sh7FFF_FFFF, 8'd0));
        send_beat(make_beat(rlrsl_pkg::OP_LOG, 32'd20, 32'sh8000_0000, 8'd0));
        send_beat(make_beat(rlrsl_pkg::OP_LOG, 32'd20, 32'sh0000_0005, 8'd0));
        send_beat(make_beat(rlrsl_pkg::OP_LOG, 32'd15, 32'sh0000_0005, 8'd0));
        // same value extends the open run
        send_beat(make_beat(rlrsl_pkg::OP_LOG, 32'd30, 32'sh8000_0000, 8'd0));
        send_beat(make_beat(rlrsl_pkg::OP_LOG, 32'd31, rlrsl_pkg::MARK_LOW_RESET, 8'd0));
        send_beat(make_beat(rlrsl_pkg::OP_LOG, 32'd32, rlrsl_pkg::MARK_HIGH_RESET, 8'd0));
        send_beat(make_beat(rlrsl_pkg::OP_LOG, 32'd33, 32'sh0000_0000, 8'd0));
        send_beat(make_beat(rlrsl_pkg::OP_READ, '0, '0, 8'd0));
        send_beat(make_beat(rlrsl_pkg::OP_READ, '0, '0, 8'd1));
        send_beat(make_beat(rlrsl_pkg::OP_READ, '0, '0, 8'd4));
        send_beat(make_beat(rlrsl_pkg::OP_READ, '0, '0, 8'd5));
        send_beat(make_beat(rlrsl_pkg::OP_READ, '0, '0, 8'd255));
        send_beat(make_beat(rlrsl_pkg::OP_LOG, 32'hFFFF_FFFF, 32'shFFFF_FFFF, 8'd0));
        send_beat(make_beat(rlrsl_pkg::OP_LOG, 32'hFFFF_FFFF, 32'sh0000_0002, 8'd0));
        send_beat(make_beat(rlrsl_pkg::OP_CLEAR, 32'hFFFF_FFFF, 32'sh7FFF_FFFF, 8'hFF));
        send_beat(make_beat(rlrsl_pkg::OP_READ, '0, '0, 8'd0));
        send_beat(make_beat(rlrsl_pkg::OP_LOG, 32'd1, 32'sh0001_8000, 8'd0));
        send_beat(make_beat(rlrsl_pkg::OP_LOG, 32'd2, -32'sh0001_8000, 8'd0));
        send_beat(make_beat(rlrsl_pkg::OP_READ, '0, '0, 8'd1));
        drain();
    endtask

    task automatic test_ring_wrap();
        logic signed [31:0] value;
        send_beat(make_beat(rlrsl_pkg::OP_CLEAR, '0, '0, 8'd0));
        // more distinct runs than the ring holds, so the oldest get overwritten
        for (int i = 0; i < RING_DEPTH + 44; i++)
        begin
            value = $urandom;
            if (log_runs_held != 0 && value == log_ring_value[log_write_slot - 8'd1])
                value = ~value;
            send_beat(make_beat(rlrsl_pkg::OP_LOG, log_last_time + $urandom_range(1, 64),
                                value, 8'($urandom)));
        end
        send_beat(make_beat(rlrsl_pkg::OP_READ, $urandom, $urandom, 8'd0));
        send_beat(make_beat(rlrsl_pkg::OP_READ, $urandom, $urandom, 8'd255));
        repeat (40) send_beat(make_beat(rlrsl_pkg::OP_READ, $urandom, $urandom, 8'($urandom)));
        drain();
    endtask

    task automatic test_idle_phases();
        run_phase(0, 0, PHASE_BEATS);
        run_phase(57, 0, PHASE_BEATS);
        run_phase(0, 57, PHASE_BEATS);
        run_phase(25, 25, PHASE_BEATS);
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        rsp_stall_pct = 0;
        hold_armed <= 1'b1;
        @(posedge clk);
        repeat (40) send_beat(random_beat());
        drain();
    endtask

    initial
    begin
        clear_log_state();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_ring_wrap();
        test_idle_phases();
        test_backpressure();
        if (mismatch_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/rlrsl_pkg.sv
rtl/core/run_length_ring_sample_log.sv
rtl/core/rlrsl_checker.sv
bench/tb_top.sv
